// File: sv/bsc_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
`default_nettype none

package bsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_item;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
        logic       bad_char;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_ENCODE,
        JOB_DECODE,
        JOB_MARKER
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] word;
        logic [3:0]  emit;
        logic [3:0]  pad;
        logic        last;
        logic        bad;
    } job_t;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [6:0] PAD_SYM    = 7'h7F;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] i8;
        begin
            i8 = {2'b00, idx};
            if (idx < 6'd26)
                return 8'h41 + i8;
            else if (idx < 6'd52)
                return 8'h61 + i8 - 8'd26;
            else if (idx < 6'd62)
                return 8'h30 + i8 - 8'd52;
            else if (idx == 6'd62)
                return 8'h2B;
            else
                return 8'h2F;
        end
    endfunction

    // Bit 6 is set for a character outside the alphabet.
    function automatic logic [6:0] b64_sym(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            case (c) inside
                [8'h41:8'h5A]:
                begin
                    t = c - 8'h41;
                    return {1'b0, t[5:0]};
                end
                [8'h61:8'h7A]:
                begin
                    t = c - 8'h47;
                    return {1'b0, t[5:0]};
                end
                [8'h30:8'h39]:
                begin
                    t = c + 8'h04;
                    return {1'b0, t[5:0]};
                end
                8'h2B:
                    return 7'h3E;
                8'h2F:
                    return 7'h3F;
                default:
                    return {1'b1, t[5:0]};
            endcase
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/bsc_front.sv
// Front end: accepts requests, gathers groups and issues jobs to the job queue.
`default_nettype none

module bsc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic             cfg_wdata,
    input  wire logic             accept,
    input  wire bsc_pkg::in_item_t item,
    output logic                  job_push,
    output bsc_pkg::job_t         job
);
    import bsc_pkg::*;

    logic            dir_reg, dir_next;
    logic [1:0]      gc_reg, gc_next;
    logic            stopped_reg, stopped_next;
    logic            err_reg, err_next;
    logic [2:0][7:0] store_reg, store_next;

    logic [7:0]      c;
    logic [1:0]      gc_inc;
    logic [1:0]      gc_after;
    logic [7:0]      b0, b1, b2;
    logic [6:0]      sym;
    logic [6:0]      sym_use;
    logic            have;
    logic            full_grp;
    logic            grp;
    logic            err_all;
    logic [2:0][7:0] st;
    logic [6:0]      s0, s1, s2, s3;
    logic [3:0]      emit;

    always_comb
    begin
        dir_next     = dir_reg;
        gc_next      = gc_reg;
        stopped_next = stopped_reg;
        err_next     = err_reg;
        store_next   = store_reg;
        job_push     = 1'b0;
        job          = '0;

        c        = item.data_byte;
        gc_inc   = gc_reg + 2'd1;
        b0       = (gc_reg == 2'd0) ? c : store_reg[0];
        b1       = (gc_reg == 2'd1) ? c : ((gc_reg == 2'd2) ? store_reg[1] : 8'h00);
        b2       = (gc_reg == 2'd2) ? c : 8'h00;

        sym      = b64_sym(c);
        have     = (c == PAD_CHAR) || !sym[6];
        sym_use  = (c == PAD_CHAR) ? PAD_SYM : {1'b0, sym[5:0]};
        err_all  = err_reg | !have;
        full_grp = have && (gc_reg == 2'd3);
        st       = store_reg;
        gc_after = gc_reg;
        if (have && (gc_reg != 2'd3))
        begin
            st[gc_reg] = {1'b0, sym_use};
            gc_after   = gc_inc;
        end
        else if (full_grp)
        begin
            gc_after = 2'd0;
        end
        grp  = full_grp || (item.last_item && (gc_after != 2'd0));
        s0   = st[0][6:0];
        s1   = (full_grp || (gc_after > 2'd1)) ? st[1][6:0] : PAD_SYM;
        s2   = (full_grp || (gc_after > 2'd2)) ? st[2][6:0] : PAD_SYM;
        s3   = full_grp ? sym_use : PAD_SYM;
        emit = 4'b0000;

        if (accept)
        begin
            if (dir_reg == DIR_ENCODE)
            begin
                if (gc_reg != 2'd3)
                    store_next[gc_reg] = c;
                if ((gc_inc == 2'd3) || item.last_item)
                begin
                    job_push  = 1'b1;
                    job.kind  = JOB_ENCODE;
                    job.word  = {b0, b1, b2};
                    job.emit  = 4'b1111;
                    job.pad   = (gc_inc == 2'd1) ? 4'b1100 :
                                ((gc_inc == 2'd2) ? 4'b1000 : 4'b0000);
                    job.last  = item.last_item;
                    job.bad   = 1'b0;
                    gc_next   = 2'd0;
                end
                else
                begin
                    gc_next = gc_inc;
                end
            end
            else
            begin
                store_next = st;
                err_next   = err_all;
                gc_next    = grp ? 2'd0 : gc_after;
                if (grp && !stopped_reg)
                begin
                    if (s0[6] || s1[6])
                        stopped_next = 1'b1;
                    else
                        emit = {1'b0, !s3[6], !s2[6], 1'b1};
                end
                if (emit != 4'b0000)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_DECODE;
                    job.word = {s0[5:0], s1[5:0], s2[5:0], s3[5:0]};
                    job.emit = emit;
                    job.pad  = 4'b0000;
                    job.last = item.last_item;
                    job.bad  = item.last_item & err_all;
                end
                else if (item.last_item)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_MARKER;
                    job.word = '0;
                    job.emit = 4'b0001;
                    job.pad  = 4'b0000;
                    job.last = 1'b1;
                    job.bad  = err_all;
                end
            end
            if (item.last_item)
            begin
                gc_next      = 2'd0;
                stopped_next = 1'b0;
                err_next     = 1'b0;
            end
        end

        if (cfg_wen)
        begin
            dir_next     = cfg_wdata;
            gc_next      = 2'd0;
            stopped_next = 1'b0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= DIR_ENCODE;
            gc_reg      <= 2'd0;
            stopped_reg <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            dir_reg     <= dir_next;
            gc_reg      <= gc_next;
            stopped_reg <= stopped_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    // A stopped decode stream can only exist while decoding.
    a_stopped_decode: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (dir_reg != DIR_ENCODE))
        else $error("decode stop flag set while encoding");

    // Encoding flushes on the third byte, so the count never holds three.
    a_encode_count: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg == DIR_ENCODE) |-> (gc_reg != 2'd3))
        else $error("encode group count reached three");

endmodule

`default_nettype wire

// File: sv/bsc_job_fifo.sv
// Small job queue between the front end and the result sequencer.
`default_nettype none

module bsc_job_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire bsc_pkg::job_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output bsc_pkg::job_t      rd_data,
    output logic               empty
);
    import bsc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("job queue count exceeds its depth");

endmodule

`default_nettype wire

// File: sv/bsc_back.sv
// Result sequencer: turns each job into its results, one per cycle while pop is high.
`default_nettype none

module bsc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire bsc_pkg::job_t job,
    output logic               job_take,
    input  wire logic          pop,
    output logic               empty,
    output bsc_pkg::out_item_t out_item
);
    import bsc_pkg::*;

    job_t       job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [3:0] rem_reg, rem_next;

    logic [1:0] pos;
    logic [3:0] pos_mask;
    logic       run_last;
    logic       done;
    logic [5:0] sel6;
    logic [7:0] sel8;

    always_comb
    begin
        if (rem_reg[0])
            pos = 2'd0;
        else if (rem_reg[1])
            pos = 2'd1;
        else if (rem_reg[2])
            pos = 2'd2;
        else
            pos = 2'd3;
        pos_mask = 4'b0001 << pos;
        run_last = (rem_reg & ~pos_mask) == 4'b0000;

        case (pos)
            2'd0:    sel6 = job_reg.word[23:18];
            2'd1:    sel6 = job_reg.word[17:12];
            2'd2:    sel6 = job_reg.word[11:6];
            default: sel6 = job_reg.word[5:0];
        endcase
        case (pos)
            2'd0:    sel8 = job_reg.word[23:16];
            2'd1:    sel8 = job_reg.word[15:8];
            default: sel8 = job_reg.word[7:0];
        endcase

        out_item = '0;
        case (job_reg.kind)
            JOB_ENCODE:
            begin
                out_item.out_byte   = job_reg.pad[pos] ? PAD_CHAR : b64_char(sel6);
                out_item.byte_valid = 1'b1;
            end
            JOB_DECODE:
            begin
                out_item.out_byte   = sel8;
                out_item.byte_valid = 1'b1;
            end
            default:
            begin
                out_item.out_byte   = 8'h00;
                out_item.byte_valid = 1'b0;
            end
        endcase
        out_item.run_last   = run_last;
        out_item.stream_end = run_last && job_reg.last;
        out_item.bad_char   = run_last && job_reg.bad;

        empty    = !busy_reg;
        done     = pop && busy_reg;
        job_take = job_valid && (!busy_reg || (done && run_last));

        busy_next = busy_reg;
        rem_next  = rem_reg;
        job_next  = job_reg;
        if (done)
        begin
            rem_next = rem_reg & ~pos_mask;
            if (run_last)
                busy_next = 1'b0;
        end
        if (job_take)
        begin
            busy_next = 1'b1;
            rem_next  = job.emit;
            job_next  = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= 4'b0000;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != 4'b0000))
        else $error("sequencer busy with no result left");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !pop) |=> ($stable(job_reg) && $stable(rem_reg)))
        else $error("current job changed while its result was stalled");

endmodule

`default_nettype wire

// File: sv/base64_stream_codec.sv
// Top level of the base64 stream codec: front end, job queue and result sequencer.
//
//   Channel   Handshake          Payload
//   input     push / full        in_item  (data_byte, last_item)
//   result    empty / pop        out_item (out_byte, byte_valid, run_last, stream_end, bad_char)
//   config    cfg_wen            cfg_wdata (direction)
//
// A request is taken whenever the job queue has room; results leave at one per cycle while popped.
// Encoding yields four results per three bytes, so the result port sets the sustained rate.
// A stalled result port fills the job queue of JOB_DEPTH jobs, after which full rises.
// Reset clears the direction to encode and empties the queue and the sequencer.
`default_nettype none

module base64_stream_codec #(
    parameter int JOB_DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wen,
    input  wire logic              cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire bsc_pkg::in_item_t in_item,
    output logic                   empty,
    input  wire logic              pop,
    output bsc_pkg::out_item_t     out_item
);
    import bsc_pkg::*;

    logic job_push;
    job_t job_in;
    logic fifo_full;
    logic fifo_empty;
    job_t job_head;
    logic job_take;

    assign full = fifo_full;

    bsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .accept    (push && !fifo_full),
        .item      (in_item),
        .job_push  (job_push),
        .job       (job_in)
    );

    bsc_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (fifo_full),
        .rd_en   (job_take),
        .rd_data (job_head),
        .empty   (fifo_empty)
    );

    bsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!fifo_empty),
        .job       (job_head),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// File: sim/base64_stream_codec_tb.sv
// Self-checking testbench for the base64 stream codec, with its own encode and decode predictor.
`default_nettype none

module base64_stream_codec_tb;

    localparam logic       DIR_ENC      = 1'b0;
    localparam logic       DIR_DEC      = 1'b1;
    localparam logic [7:0] EQUALS_CHAR  = 8'h3D;
    localparam logic [7:0] PADDING_SYM  = 8'h7F;
    localparam int         SETTLE_TICKS = 16;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 push      = 1'b0;
    logic                 pop       = 1'b0;
    logic                 full;
    logic                 empty;
    bsc_pkg::in_item_t    in_item   = '0;
    bsc_pkg::out_item_t   out_item;

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    bsc_pkg::out_item_t expected_results[$];
    bsc_pkg::out_item_t burst[$];

    logic       codec_dir;
    logic [7:0] group_held [3];
    int         held_count;
    logic       stream_stopped;
    logic       stream_bad;

    int send_idle_pct = 12;
    int recv_idle_pct = 59;
    int errors        = 0;

    base64_stream_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void report_field(input string name, input int want, input int got);
        $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
        errors++;
    endfunction

    always @(posedge clk)
    begin : check_result
        bsc_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.out_byte !== want.out_byte)
                    report_field("out_byte", want.out_byte, out_item.out_byte);
                if (out_item.byte_valid !== want.byte_valid)
                    report_field("byte_valid", want.byte_valid, out_item.byte_valid);
                if (out_item.run_last !== want.run_last)
                    report_field("run_last", want.run_last, out_item.run_last);
                if (out_item.stream_end !== want.stream_end)
                    report_field("stream_end", want.stream_end, out_item.stream_end);
                if (out_item.bad_char !== want.bad_char)
                    report_field("bad_char", want.bad_char, out_item.bad_char);
            end
        end
    end

    function automatic void reset_stream();
        held_count     = 0;
        stream_stopped = 1'b0;
        stream_bad     = 1'b0;
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic v);
        bsc_pkg::out_item_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = v;
        burst        = {burst, r};
    endfunction

    function automatic int symbol_of(input logic [7:0] c);
        int idx;
        idx = 64;
        for (int i = 63; i >= 0; i--)
            if (b64_alphabet[i] == c)
                idx = i;
        return idx;
    endfunction

    function automatic void encode_triple(input int n);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] c [4];
        b0 = group_held[0];
        b1 = (n > 1) ? group_held[1] : 8'h00;
        b2 = (n > 2) ? group_held[2] : 8'h00;
        c[0] = b0[7:2];
        c[1] = {b0[1:0], b1[7:4]};
        c[2] = {b1[3:0], b2[7:6]};
        c[3] = b2[5:0];
        for (int k = 0; k < 4; k++)
            add_result((k <= n) ? b64_alphabet[c[k]] : EQUALS_CHAR, 1'b1);
    endfunction

    function automatic void decode_quad(input logic [7:0] s0, input logic [7:0] s1,
                                        input logic [7:0] s2, input logic [7:0] s3);
        if (!stream_stopped)
        begin
            if (s0[6] || s1[6])
                stream_stopped = 1'b1;
            else
            begin
                add_result({s0[5:0], s1[5:4]}, 1'b1);
                if (!s2[6])
                    add_result({s1[3:0], s2[5:2]}, 1'b1);
                if (!s3[6])
                    add_result({s2[1:0], s3[5:0]}, 1'b1);
            end
        end
    endfunction

    function automatic void predict_codec(input logic [7:0] c, input logic l);
        logic [7:0] sym;
        logic       have;
        int         v;
        burst = {};
        if (codec_dir == DIR_ENC)
        begin
            group_held[held_count] = c;
            held_count++;
            if (held_count == 3 || l)
            begin
                encode_triple(held_count);
                held_count = 0;
            end
        end
        else
        begin
            v    = symbol_of(c);
            have = 1'b1;
            sym  = 8'h00;
            if (c == EQUALS_CHAR)
                sym = PADDING_SYM;
            else if (v < 64)
                sym = v[7:0];
            else
            begin
                stream_bad = 1'b1;
                have       = 1'b0;
            end
            if (have)
            begin
                if (held_count >= 3)
                begin
                    decode_quad(group_held[0], group_held[1], group_held[2], sym);
                    held_count = 0;
                end
                else
                begin
                    group_held[held_count] = sym;
                    held_count++;
                end
            end
            if (l && held_count != 0)
            begin
                decode_quad(group_held[0],
                            (held_count > 1) ? group_held[1] : PADDING_SYM,
                            (held_count > 2) ? group_held[2] : PADDING_SYM,
                            PADDING_SYM);
                held_count = 0;
            end
            if (l && burst.size() == 0)
                add_result(8'h00, 1'b0);
        end
        if (burst.size() > 0)
        begin
            burst[burst.size() - 1].run_last = 1'b1;
            if (l)
            begin
                burst[burst.size() - 1].stream_end = 1'b1;
                burst[burst.size() - 1].bad_char   = (codec_dir == DIR_DEC) ? stream_bad : 1'b0;
            end
        end
        if (l)
            reset_stream();
        expected_results = {expected_results, burst};
    endfunction

    task automatic send_request(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= {d, l};
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_codec(d, l);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= dir;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        codec_dir = dir;
        reset_stream();
    endtask

    task automatic send_text(input string s, input logic end_stream);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], end_stream && (i == s.len() - 1));
    endtask

    task automatic test_encode_groups();
        write_direction(DIR_ENC);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h80, 1'b0);
        send_text("M", 1'b1);
        send_text("Ma", 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
    endtask

    task automatic test_decode_rules();
        write_direction(DIR_DEC);
        send_text("/+9z", 1'b0);
        send_text("TWE=", 1'b1);
        send_text("QU=B", 1'b1);
        send_text("=AAA", 1'b0);
        send_text("!", 1'b1);
        send_text("TW", 1'b1);
    endtask

    // A direction write in the middle of a group must throw the partial group away.
    task automatic test_direction_write();
        write_direction(DIR_ENC);
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b0);
        write_direction(DIR_ENC);
        send_request(8'h56, 1'b1);
        write_direction(DIR_DEC);
        send_text("TW", 1'b0);
        write_direction(DIR_DEC);
        send_text("Q", 1'b1);
    endtask

    task automatic random_encode_streams(input int items);
        int sent;
        int len;
        sent = 0;
        write_direction(DIR_ENC);
        while (sent < items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 7);
            for (int i = 0; i < len; i++)
            begin
                send_request(8'($urandom_range(255)),
                             (i == len - 1) && ($urandom_range(99) < 85));
                sent++;
            end
            if ($urandom_range(9) == 0)
                drain_results();
        end
    endtask

    task automatic random_decode_streams(input int items);
        int         sent;
        int         groups;
        int         shape;
        logic [7:0] chars [$];
        sent = 0;
        write_direction(DIR_DEC);
        while (sent < items)
        begin
            chars = {};
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    chars = {chars, 8'($urandom_range(255))};
            end
            else
            begin
                groups = $urandom_range(1, 3);
                repeat (groups * 4)
                    chars = {chars, b64_alphabet[$urandom_range(63)]};
                shape = $urandom_range(4);
                if (shape == 1)
                begin
                    chars[chars.size() - 1] = EQUALS_CHAR;
                    chars[chars.size() - 2] = EQUALS_CHAR;
                end
                else if (shape == 2)
                    chars[chars.size() - 1] = EQUALS_CHAR;
                else if (shape == 3)
                    repeat ($urandom_range(1, 3)) void'(chars.pop_back());
                foreach (chars[i])
                begin
                    if ($urandom_range(99) < 6)
                        chars[i] = 8'($urandom_range(255));
                    else if ($urandom_range(99) < 4)
                        chars[i] = EQUALS_CHAR;
                end
            end
            foreach (chars[i])
            begin
                send_request(chars[i], (i == chars.size() - 1) && ($urandom_range(99) < 90));
                sent++;
            end
            if ($urandom_range(11) == 0)
                drain_results();
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_encode_streams(45);
        random_decode_streams(95);
    endtask

    initial
    begin
        codec_dir = DIR_ENC;
        reset_stream();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_groups();
        test_decode_rules();
        test_direction_write();
        test_random_traffic(12, 59);
        test_random_traffic(59, 12);
        test_random_traffic(0, 0);
        drain_results();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
